// ----- src/sorted_set_table_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Sorted set table assertion macros
// Shared concurrent assertion forms. Every module that uses them has clk
// and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SORTED_SET_TABLE_UNIT_ASSERT_SVH
`define SORTED_SET_TABLE_UNIT_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define SST_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the trigger holds, the outcome must hold in the following cycle.
`define SST_ASSERT_NEXT(lbl, trig, outcome, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (outcome)) \
    else $error(msg);

`endif

// ----- src/sst_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted set table package
// Field widths, operation and status codes, and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int OP_BITS       = 2;
  localparam int VALUE_IN_BITS = 32;
  localparam int STATUS_BITS   = 2;
  localparam int POS_BITS      = 6;

  // Operation codes. The unused code behaves as a lookup.
  localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_BITS-1:0] OP_LOOKUP = 2'd2;

  // Result status codes.
  localparam logic [STATUS_BITS-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_PRESENT   = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_INSERT,
    ACT_REMOVE
  } act_t;

  typedef struct packed {
    logic load;       // take the input beat
    logic scan_rd;    // read the entry at the scan index
    logic scan_step;  // entry below key, advance the scan index
    logic scan_stop;  // entry not below key, record the match
    logic decide;     // latch status, position and the action
    logic walk_rd;    // read the neighbor of the walk index
    logic walk_wr;    // write the neighbor into the walk index
    logic put;        // write the key at its sorted place
    logic count_dec;  // one entry removed
    logic out_load;   // load the result register
  } sst_cmd_t;

  typedef struct packed {
    logic scan_end;   // scan index reached the count
    logic entry_low;  // entry just read is below the key
    act_t action;     // action that the current decision calls for
    logic walk_ins;   // the latched action is an insert
    logic walk_end;   // shifting is complete
    logic out_free;   // the result register can take a new result
  } sst_stat_t;

endpackage

// ----- src/sst_if.sv -----
// ----------------------------------------------------------------------------
// Sorted set table channels
// Valid/ready channels for operation beats and result beats.
// ----------------------------------------------------------------------------
interface sst_in_if;
  import sst_pkg::*;

  logic                            valid;
  logic                            ready;
  logic [OP_BITS-1:0]              op;
  logic signed [VALUE_IN_BITS-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

interface sst_out_if;
  import sst_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [STATUS_BITS-1:0] status;
  logic                   found;
  logic [POS_BITS-1:0]    position;
  logic [POS_BITS-1:0]    count;

  modport source (output valid, output status, output found, output position,
                  output count, input ready);
  modport sink (input valid, input status, input found, input position,
                input count, output ready);
endinterface

// ----- src/sst_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sorted set table controller
// Sequences the scan, the decision, the shift walk and the result load.
// ----------------------------------------------------------------------------
module sst_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sst_pkg::sst_stat_t st,
  output sst_pkg::sst_cmd_t  cmd
);
  import sst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_CHK,
    S_SCAN_CMP,
    S_DECIDE,
    S_WALK_CHK,
    S_WALK_WR,
    S_PUT,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (st.scan_end) begin
          state_nxt = S_DECIDE;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt   = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (st.entry_low) begin
          cmd.scan_step = 1'b1;
          state_nxt     = S_SCAN_CHK;
        end else begin
          cmd.scan_stop = 1'b1;
          state_nxt     = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = (st.action == ACT_NONE) ? S_FINISH : S_WALK_CHK;
      end
      S_WALK_CHK: begin
        if (!st.walk_end) begin
          cmd.walk_rd = 1'b1;
          state_nxt   = S_WALK_WR;
        end else if (st.walk_ins) begin
          state_nxt = S_PUT;
        end else begin
          cmd.count_dec = 1'b1;
          state_nxt     = S_FINISH;
        end
      end
      S_WALK_WR: begin
        cmd.walk_wr = 1'b1;
        state_nxt   = S_WALK_CHK;
      end
      S_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/sst_dp.sv -----
// ----------------------------------------------------------------------------
// Sorted set table datapath
// Entry memory, scan and walk indexes, entry count, decision logic and the
// result register.
// ----------------------------------------------------------------------------
`include "sorted_set_table_unit_assert.svh"

module sst_dp #(
  parameter int CAPACITY_ENTRIES = 32,
  parameter int VALUE_BITS       = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic [sst_pkg::OP_BITS-1:0]             in_op,
  input  logic signed [sst_pkg::VALUE_IN_BITS-1:0] in_value,
  input  sst_pkg::sst_cmd_t                       cmd,
  output sst_pkg::sst_stat_t                      st,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [sst_pkg::STATUS_BITS-1:0]         out_status,
  output logic                                    out_found,
  output logic [sst_pkg::POS_BITS-1:0]            out_position,
  output logic [sst_pkg::POS_BITS-1:0]            out_count
);
  import sst_pkg::*;

  localparam int AW = $clog2(CAPACITY_ENTRIES);
  localparam int CW = $clog2(CAPACITY_ENTRIES + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY_ENTRIES);

  logic signed [VALUE_BITS-1:0] mem [CAPACITY_ENTRIES];
  logic signed [VALUE_BITS-1:0] rd_data_r;

  logic [OP_BITS-1:0]           op_r;
  logic signed [VALUE_BITS-1:0] key_r;
  logic [CW-1:0]                count_r;
  logic [CW-1:0]                idx_r;
  logic [CW-1:0]                walk_r;
  logic                         found_r;
  act_t                         act_r;
  logic [STATUS_BITS-1:0]       status_r;
  logic [CW-1:0]                rpos_r;

  logic                         out_valid_r;
  logic [STATUS_BITS-1:0]       out_status_r;
  logic                         out_found_r;
  logic [POS_BITS-1:0]          out_pos_r;
  logic [POS_BITS-1:0]          out_count_r;

  act_t                         act_nxt;
  logic [STATUS_BITS-1:0]       status_nxt;
  logic [CW-1:0]                rpos_nxt;
  logic                         full;
  logic [CW-1:0]                walk_dn;
  logic [CW-1:0]                walk_up;
  logic                         rd_en;
  logic [AW-1:0]                rd_addr;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic signed [VALUE_BITS-1:0] wr_data;

  assign full    = (count_r == CAP);
  assign walk_dn = walk_r - CW'(1);
  assign walk_up = walk_r + CW'(1);

  // The scan stops at the first entry not below the key, so idx_r is the
  // insert place when the value is absent and its index when present.
  always_comb begin
    act_nxt    = ACT_NONE;
    status_nxt = ST_DONE;
    rpos_nxt   = idx_r;
    case (op_r)
      OP_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
          if (!found_r) begin
            rpos_nxt = count_r;
          end
        end else if (found_r) begin
          status_nxt = ST_PRESENT;
        end else begin
          act_nxt = ACT_INSERT;
        end
      end
      OP_REMOVE: begin
        if (found_r) begin
          act_nxt = ACT_REMOVE;
        end else begin
          status_nxt = ST_NOT_FOUND;
          rpos_nxt   = count_r;
        end
      end
      default: begin
        if (!found_r) begin
          status_nxt = ST_NOT_FOUND;
          rpos_nxt   = count_r;
        end
      end
    endcase
  end

  always_comb begin
    st.scan_end  = (idx_r == count_r);
    st.entry_low = (rd_data_r < key_r);
    st.action    = act_nxt;
    st.walk_ins  = (act_r == ACT_INSERT);
    st.walk_end  = (act_r == ACT_INSERT) ? (walk_r == idx_r) : (walk_up >= count_r);
    st.out_free  = !out_valid_r || out_ready;
  end

  // Insert moves entries up from the top, remove moves them down from the
  // hole; each move is a read beat followed by a write beat.
  always_comb begin
    rd_en   = cmd.scan_rd || cmd.walk_rd;
    rd_addr = (act_r == ACT_INSERT) ? walk_dn[AW-1:0] : walk_up[AW-1:0];
    if (cmd.scan_rd) begin
      rd_addr = idx_r[AW-1:0];
    end
    wr_en   = cmd.walk_wr || cmd.put;
    wr_addr = cmd.put ? idx_r[AW-1:0] : walk_r[AW-1:0];
    wr_data = cmd.put ? key_r : rd_data_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      key_r   <= VALUE_BITS'(in_value);
      idx_r   <= '0;
      found_r <= 1'b0;
    end
    if (cmd.scan_step) begin
      idx_r <= idx_r + CW'(1);
    end
    if (cmd.scan_stop) begin
      found_r <= (rd_data_r == key_r);
    end
    if (cmd.decide) begin
      status_r <= status_nxt;
      rpos_r   <= rpos_nxt;
      walk_r   <= (act_nxt == ACT_INSERT) ? count_r : idx_r;
    end
    if (cmd.walk_wr) begin
      walk_r <= (act_r == ACT_INSERT) ? walk_dn : walk_up;
    end
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_found_r  <= found_r;
      out_pos_r    <= POS_BITS'(rpos_r);
      out_count_r  <= POS_BITS'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      act_r       <= ACT_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.put) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.count_dec) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.decide) begin
        act_r <= act_nxt;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_found    = out_found_r;
  assign out_position = out_pos_r;
  assign out_count    = out_count_r;

  `SST_ASSERT_ALWAYS(a_count_bound, count_r <= CAP, "entry count above capacity")
  `SST_ASSERT_ALWAYS(a_put_room, !cmd.put || (count_r < CAP), "insert into a full store")
  `SST_ASSERT_ALWAYS(a_walk_range, !cmd.walk_rd || (walk_r <= count_r),
                     "shift walk outside the held entries")
  `SST_ASSERT_NEXT(a_remove_shrinks, cmd.count_dec, count_r == $past(count_r) - CW'(1),
                   "remove did not lower the count by one")

endmodule

// ----- src/sorted_set_table_unit.sv -----
// ----------------------------------------------------------------------------
// Sorted set table unit
// Holds distinct signed values in ascending order in an entry memory and
// applies one insert, remove or lookup per operation beat.
//
//   Channel  | Direction | Payload
//   ---------+-----------+----------------------------------
//   in_req   | in        | op, value
//   out_rsp  | out       | status, found, position, count
//
// An operation scans the entries below its key one by one, then decides and,
// for an insert or a remove, shifts the entries past the place one by one
// before its result load. The single read port sets this: each scan step and
// each shift move costs a read beat and a compare or write beat. Reset clears
// the count, the latched action, the result valid flag and the FSM state.
// A new beat is taken while a result waits; a stalled output holds the next.
// ----------------------------------------------------------------------------
module sorted_set_table_unit #(
  parameter int CAPACITY_ENTRIES = 32,
  parameter int VALUE_BITS       = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  sst_in_if.sink       in_req,
  sst_out_if.source    out_rsp
);
  import sst_pkg::*;

  sst_cmd_t  cmd;
  sst_stat_t st;

  sst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .st       (st),
    .cmd      (cmd)
  );

  sst_dp #(
    .CAPACITY_ENTRIES (CAPACITY_ENTRIES),
    .VALUE_BITS       (VALUE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_op        (in_req.op),
    .in_value     (in_req.value),
    .cmd          (cmd),
    .st           (st),
    .out_valid    (out_rsp.valid),
    .out_ready    (out_rsp.ready),
    .out_status   (out_rsp.status),
    .out_found    (out_rsp.found),
    .out_position (out_rsp.position),
    .out_count    (out_rsp.count)
  );

endmodule

// ----- verif/sorted_set_table_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set table unit testbench
// Drives insert, remove and lookup beats into the sorted set table and
// checks every result beat against a software copy of the ordered set.
// A directed opening covers the value extremes and the corner cases. A
// random part then alternates between filling and draining the set, so the
// store runs full and empty many times. Three idling phases vary the
// stalls on both channels.
// ----------------------------------------------------------------------------
module sorted_set_table_unit_test;
  import sst_pkg::*;

  localparam int                   SET_CAPACITY = 32;
  localparam logic [OP_BITS-1:0]   OP_SPARE     = 2'd3;
  localparam int                   RANDOM_OPS   = 1650;
  localparam int                   PHASE_OPS    = RANDOM_OPS / 3;
  localparam int                   CHUNK_OPS    = 70;
  localparam int                   POOL_SIZE    = 48;
  localparam int                   DRAIN_CYCLES = 4 * SET_CAPACITY + 5 + 20;

  typedef logic signed [VALUE_IN_BITS-1:0] value_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic                   found;
    logic [POS_BITS-1:0]    position;
    logic [POS_BITS-1:0]    count;
  } set_result_t;

  // Mirror of the ordered set, plus the results still owed by the block.
  class set_scoreboard;
    value_t      held[SET_CAPACITY];
    int          held_count;
    set_result_t owed[$];
    int          mismatches;

    function void note_op(logic [OP_BITS-1:0] op, value_t value);
      set_result_t res;
      int          n;
      int          pos;
      bit          hit;
      n   = held_count;
      pos = 0;
      while (pos < n && held[pos] < value) pos++;
      hit = (pos < n) && (held[pos] == value);
      case (op)
        OP_INSERT: begin
          if (n >= SET_CAPACITY) begin
            res.status = ST_FULL;
            if (!hit) pos = n;
          end else if (hit) begin
            res.status = ST_PRESENT;
          end else begin
            for (int i = n; i > pos; i--) held[i] = held[i-1];
            held[pos] = value;
            n++;
            res.status = ST_DONE;
          end
        end
        OP_REMOVE: begin
          if (hit) begin
            for (int i = pos; i + 1 < n; i++) held[i] = held[i+1];
            n--;
            res.status = ST_DONE;
          end else begin
            res.status = ST_NOT_FOUND;
            pos = n;
          end
        end
        default: begin
          // Lookup, and the spare code, which acts the same way.
          if (hit) begin
            res.status = ST_DONE;
          end else begin
            res.status = ST_NOT_FOUND;
            pos = n;
          end
        end
      endcase
      held_count   = n;
      res.found    = hit;
      res.position = pos[POS_BITS-1:0];
      res.count    = n[POS_BITS-1:0];
      owed.push_back(res);
    endfunction

    function void check_result(set_result_t got);
      set_result_t want;
      if (owed.size() == 0) begin
        $error("result beat with no operation outstanding");
        mismatches++;
        return;
      end
      want = owed.pop_front();
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
        mismatches++;
      end
      if (got.found !== want.found) begin
        $error("found mismatch: expected %0d, actual %0d", want.found, got.found);
        mismatches++;
      end
      if (got.position !== want.position) begin
        $error("position mismatch: expected %0d, actual %0d", want.position, got.position);
        mismatches++;
      end
      if (got.count !== want.count) begin
        $error("count mismatch: expected %0d, actual %0d", want.count, got.count);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   tx_idle_pct;
  int   rx_idle_pct;

  set_scoreboard book;
  value_t        pool[POOL_SIZE];

  sst_in_if  in_req();
  sst_out_if out_rsp();

  sorted_set_table_unit u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      book.check_result('{out_rsp.status, out_rsp.found, out_rsp.position, out_rsp.count});
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_op(logic [OP_BITS-1:0] op, value_t value);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_req.valid <= 1'b0;
      @(negedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.op    <= op;
    in_req.value <= value;
    do @(posedge clk); while (!in_req.ready);
    book.note_op(op, value);
    @(negedge clk);
  endtask

  function automatic logic [OP_BITS-1:0] pick_op(bit filling);
    int r;
    r = $urandom_range(99);
    if (filling) begin
      if (r < 65) return OP_INSERT;
      if (r < 78) return OP_REMOVE;
      if (r < 95) return OP_LOOKUP;
    end else begin
      if (r < 20) return OP_INSERT;
      if (r < 70) return OP_REMOVE;
      if (r < 95) return OP_LOOKUP;
    end
    return OP_SPARE;
  endfunction

  // Mostly values from a small pool, so that hits, duplicates and a full
  // store are common; the rest spread over the whole range.
  function automatic value_t pick_value();
    if ($urandom_range(99) < 75) return pool[$urandom_range(POOL_SIZE-1)];
    return value_t'($urandom);
  endfunction

  task automatic run_random(int ops);
    bit filling;
    for (int i = 0; i < ops; i++) begin
      if (i % CHUNK_OPS == 0) filling = ~filling;
      send_op(pick_op(filling), pick_value());
    end
  endtask

  initial begin
    value_t int_min;
    value_t int_max;
    book          = new();
    int_min       = {1'b1, {(VALUE_IN_BITS-1){1'b0}}};
    int_max       = {1'b0, {(VALUE_IN_BITS-1){1'b1}}};
    clk           = 1'b0;
    rst_n         = 1'b0;
    tx_idle_pct   = 25;
    rx_idle_pct   = 58;
    in_req.valid  = 1'b0;
    in_req.op     = OP_LOOKUP;
    in_req.value  = '0;
    out_rsp.ready = 1'b0;

    pool[0] = int_min;
    pool[1] = int_max;
    pool[2] = 0;
    pool[3] = -1;
    pool[4] = 1;
    for (int i = 5; i < POOL_SIZE; i++) pool[i] = value_t'($urandom);

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty set, extremes at both ends, duplicates, the spare code, and
    // removal from the front, back and middle.
    send_op(OP_LOOKUP, 0);
    send_op(OP_REMOVE, 5);
    send_op(OP_INSERT, 0);
    send_op(OP_INSERT, int_min);
    send_op(OP_INSERT, int_max);
    send_op(OP_INSERT, -1);
    send_op(OP_INSERT, 1);
    send_op(OP_INSERT, 0);
    send_op(OP_LOOKUP, int_min);
    send_op(OP_LOOKUP, int_max);
    send_op(OP_LOOKUP, 7);
    send_op(OP_SPARE, -1);
    send_op(OP_SPARE, 9);
    send_op(OP_REMOVE, int_max);
    send_op(OP_REMOVE, int_min);
    send_op(OP_REMOVE, 0);
    send_op(OP_REMOVE, 0);
    send_op(OP_INSERT, 32'h5555_5555);
    send_op(OP_INSERT, 32'hAAAA_AAAA);
    send_op(OP_LOOKUP, 32'hAAAA_AAAA);

    run_random(PHASE_OPS);
    tx_idle_pct = 58;
    rx_idle_pct = 25;
    run_random(PHASE_OPS);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(RANDOM_OPS - 2 * PHASE_OPS);
    in_req.valid <= 1'b0;

    while (book.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (book.mismatches == 0 && book.owed.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/sst_pkg.sv
src/sst_if.sv
src/sst_ctrl.sv
src/sst_dp.sv
src/sorted_set_table_unit.sv
verif/sorted_set_table_unit_test.sv
